/* hdl/bounded_deque_with_cursor_macros.svh */
// Assertion macros for the bounded deque checker.
// Each macro expects clk and arst_n in scope at the point of use.
`ifndef BOUNDED_DEQUE_WITH_CURSOR_MACROS_SVH
`define BOUNDED_DEQUE_WITH_CURSOR_MACROS_SVH

// same-cycle implication
`define BDQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/bdq_pkg.sv */
// Shared types for the bounded deque with cursor.
// Command and status codes; no dependencies.
package bdq_pkg;

	typedef enum logic [3:0] {
		CMD_PUSH_FRONT   = 4'd0,
		CMD_PUSH_BACK    = 4'd1,
		CMD_POP_FRONT    = 4'd2,
		CMD_POP_BACK     = 4'd3,
		CMD_CLEAR        = 4'd4,
		CMD_CURSOR_FIRST = 4'd5,
		CMD_CURSOR_LAST  = 4'd6,
		CMD_CURSOR_NEXT  = 4'd7,
		CMD_CURSOR_PREV  = 4'd8,
		CMD_QUERY        = 4'd9
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_NULL  = 2'd3
	} status_t;

endpackage

/* hdl/bdq_if.sv */
// Valid/ready channel interfaces for command and result beats.
// Depends on bdq_pkg.
interface bdq_cmd_if import bdq_pkg::*; #(
	parameter int DATA_WIDTH = 32
) ();
	logic                  valid;
	logic                  ready;
	cmd_t                  command;
	logic [DATA_WIDTH-1:0] value;

	modport source (output valid, command, value, input ready);
	modport sink   (input valid, command, value, output ready);
endinterface

interface bdq_res_if import bdq_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int CNT_W      = 5
) ();
	logic                  valid;
	logic                  ready;
	status_t               status;
	logic [CNT_W-1:0]      count;
	logic                  is_empty;
	logic                  cursor_valid;
	logic [DATA_WIDTH-1:0] cursor_data;
	logic                  has_next;
	logic                  has_prev;

	modport source (output valid, status, count, is_empty, cursor_valid, cursor_data,
		has_next, has_prev, input ready);
	modport sink   (input valid, status, count, is_empty, cursor_valid, cursor_data,
		has_next, has_prev, output ready);
endinterface

/* hdl/bdq_ram.sv */
// Ring element store: one write port, one registered read port.
// No dependencies.
module bdq_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

/* hdl/bounded_deque_with_cursor.sv */
// Bounded double-ended queue with cursor, top level.
// Depends on bdq_pkg, bdq_cmd_if, bdq_res_if and bdq_ram.
//
// Usage:
//   cmd carries one command beat (command code, push value); res returns
//   exactly one result beat per command: status, count, empty flag and the
//   cursor view (valid, data under cursor, has_next, has_prev).
//   The result of a command is registered: it is presented from the edge
//   that accepts it onwards and is taken on the first res handshake.
//   Throughput is one command per cycle while res is not stalled; each
//   command does at most one write and one read of the ring store, the
//   read giving the element under the cursor.
//   Elements stay in their ring slot, so the cursor follows its element while
//   the other end moves.
//   Reset empties the queue, nulls the cursor and puts the head at slot 0;
//   the store itself is not cleared.
//   While res is stalled the result is held and cmd.ready stays low, so at
//   most one result is ever outstanding.
module bounded_deque_with_cursor import bdq_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input logic         clk,
	input logic         arst_n,
	bdq_cmd_if.sink     cmd,
	bdq_res_if.source   res
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(DEPTH);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	logic [AW-1:0]         head_q, cur_q, head_n, cur_n;
	logic [CW-1:0]         count_q, count_n;
	logic                  cur_on_q, cur_on_n;
	logic                  valid_s1;
	status_t               status_s1, status_n;
	logic                  accept, full, empty;
	logic [CW-1:0]         off;
	logic [AW:0]           tail_sum, back_sum;
	logic [AW-1:0]         tail_slot, back_slot;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [DATA_WIDTH-1:0] rd_data;

	function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
		return (s == '0) ? LAST_SLOT : s - 1'b1;
	endfunction

	assign cmd.ready = !valid_s1 || res.ready;
	assign accept    = cmd.valid && cmd.ready;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign off   = empty ? '0 : count_q - 1'b1;

	assign tail_sum  = {1'b0, head_q} + (AW + 1)'(off);
	assign tail_slot = (tail_sum >= DEPTH_X) ? AW'(tail_sum - DEPTH_X) : AW'(tail_sum);
	assign back_sum  = {1'b0, head_q} + (AW + 1)'(count_q);
	assign back_slot = (back_sum >= DEPTH_X) ? AW'(back_sum - DEPTH_X) : AW'(back_sum);

	always_comb begin
		head_n   = head_q;
		count_n  = count_q;
		cur_n    = cur_q;
		cur_on_n = cur_on_q;
		status_n = ST_OK;
		wr_en    = 1'b0;
		wr_addr  = back_slot;
		unique case (cmd.command)
			CMD_PUSH_FRONT: begin
				if (full) begin
					status_n = ST_FULL;
				end else begin
					head_n  = slot_dec(head_q);
					wr_addr = slot_dec(head_q);
					wr_en   = 1'b1;
					count_n = count_q + 1'b1;
				end
			end
			CMD_PUSH_BACK: begin
				if (full) begin
					status_n = ST_FULL;
				end else begin
					wr_en   = 1'b1;
					count_n = count_q + 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else begin
					if (cur_on_q && cur_q == head_q) begin
						cur_on_n = 1'b0;
					end
					head_n  = slot_inc(head_q);
					count_n = count_q - 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else begin
					if (cur_on_q && cur_q == tail_slot) begin
						cur_on_n = 1'b0;
					end
					count_n = count_q - 1'b1;
				end
			end
			CMD_CLEAR: begin
				head_n   = '0;
				count_n  = '0;
				cur_on_n = 1'b0;
			end
			CMD_CURSOR_FIRST: begin
				cur_on_n = !empty;
				if (!empty) begin
					cur_n = head_q;
				end
			end
			CMD_CURSOR_LAST: begin
				cur_on_n = !empty;
				if (!empty) begin
					cur_n = tail_slot;
				end
			end
			CMD_CURSOR_NEXT: begin
				if (!cur_on_q) begin
					status_n = ST_NULL;
				end else if (cur_q == tail_slot) begin
					cur_on_n = 1'b0;
				end else begin
					cur_n = slot_inc(cur_q);
				end
			end
			CMD_CURSOR_PREV: begin
				if (!cur_on_q) begin
					status_n = ST_NULL;
				end else if (cur_q == head_q) begin
					cur_on_n = 1'b0;
				end else begin
					cur_n = slot_dec(cur_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			cur_q    <= '0;
			cur_on_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				head_q   <= head_n;
				count_q  <= count_n;
				cur_q    <= cur_n;
				cur_on_q <= cur_on_n;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (res.ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_n;
		end
	end

	bdq_ram #(
		.DEPTH (DEPTH),
		.WIDTH (DATA_WIDTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (accept && wr_en),
		.wr_addr (wr_addr),
		.wr_data (cmd.value),
		.rd_en   (accept),
		.rd_addr (cur_n),
		.rd_data (rd_data)
	);

	// state registers already hold the post-command view while the beat waits
	assign res.valid        = valid_s1;
	assign res.status       = status_s1;
	assign res.count        = count_q;
	assign res.is_empty     = empty;
	assign res.cursor_valid = cur_on_q;
	assign res.cursor_data  = cur_on_q ? rd_data : '0;
	assign res.has_next     = cur_on_q && (cur_q != tail_slot);
	assign res.has_prev     = cur_on_q && (cur_q != head_q);
endmodule

/* hdl/bdq_checker.sv */
// Port-level checks for the bounded deque with cursor, bound to the top level.
// Depends on bdq_pkg and bounded_deque_with_cursor_macros.svh.
`include "bounded_deque_with_cursor_macros.svh"

module bdq_checker import bdq_pkg::*; #(
	parameter int CNT_W = 5
) (
	input logic             clk,
	input logic             arst_n,
	input logic             cmd_valid,
	input logic             cmd_ready,
	input cmd_t             command,
	input logic             res_valid,
	input logic             res_ready,
	input status_t          status,
	input logic [CNT_W-1:0] count,
	input logic             cursor_valid
);
	logic cmd_beat;

	assign cmd_beat = cmd_valid && cmd_ready;

	`BDQ_ASSERT_NEXT(a_result_follows, cmd_beat, res_valid, "no result one cycle after a command")

	`BDQ_ASSERT_NEXT(a_result_held, res_valid && !res_ready, res_valid && $stable(count) && $stable(status), "stalled result changed")

	`BDQ_ASSERT_NEXT(a_clear_empties, cmd_beat && command == CMD_CLEAR, count == '0 && !cursor_valid && status == ST_OK, "clear left elements or cursor")

	`BDQ_ASSERT_NEXT(a_pop_status, cmd_beat && (command == CMD_POP_FRONT || command == CMD_POP_BACK), status == ST_OK || status == ST_EMPTY, "pop reported a foreign status")
endmodule

bind bounded_deque_with_cursor bdq_checker #(
	.CNT_W ($clog2(DEPTH + 1))
) u_bdq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.command      (cmd.command),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.status       (res.status),
	.count        (res.count),
	.cursor_valid (res.cursor_valid)
);

/* dv/bounded_deque_with_cursor_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for bounded_deque_with_cursor: directed and random command beats,
// predicted deque/cursor view per beat, random stalls on both channels.
// Depends on bdq_pkg, bdq_cmd_if, bdq_res_if and the RTL.
module bounded_deque_with_cursor_tb;
	import bdq_pkg::*;

	localparam int DEPTH      = 16;
	localparam int DATA_W     = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int RANDOM_CMDS = 2000;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_AT    = 400;
	localparam int HOLD_LEN   = 300;
	localparam int TAIL_CYCLES = 8;
	localparam logic [3:0] CMD_CODE_LAST = 4'd15;

	typedef logic [$clog2(DEPTH)-1:0] slot_t;

	typedef struct {
		cmd_t              op;
		logic [DATA_W-1:0] value;
	} deque_cmd_t;

	typedef struct {
		status_t           status;
		logic [CNT_W-1:0]  count;
		logic              is_empty;
		logic              cursor_valid;
		logic [DATA_W-1:0] cursor_data;
		logic              has_next;
		logic              has_prev;
	} deque_view_t;

	logic clk;
	logic arst_n;

	bdq_cmd_if #(.DATA_WIDTH(DATA_W)) cmd_ch ();
	bdq_res_if #(.DATA_WIDTH(DATA_W), .CNT_W(CNT_W)) res_ch ();

	bounded_deque_with_cursor #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DATA_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch.sink),
		.res(res_ch.source)
	);

	deque_cmd_t  pending_cmds[$];
	deque_view_t expected_views[$];

	// predicted deque state
	logic [DATA_W-1:0] ring[DEPTH];
	slot_t             head;
	logic [CNT_W-1:0]  fill;
	slot_t             cur;
	logic              cur_on;

	int  mismatch_count = 0;
	int  cmds_taken = 0;
	int  idle_cycles = 0;
	int  cycle_no = 0;
	int  cmd_gap = 0;
	int  res_gap = 0;
	int  hold_left = 0;
	bit  hold_done = 0;
	bit  calm = 0;
	bit  cmd_beat;
	bit  res_beat;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return DATA_W'($urandom());
		endcase
	endfunction

	task automatic add_cmd(cmd_t op, logic [DATA_W-1:0] v);
		deque_cmd_t c;
		c.op = op;
		c.value = v;
		pending_cmds.push_back(c);
	endtask

	task automatic add_rand(cmd_t op);
		add_cmd(op, rand_value());
	endtask

	task automatic flag_error(string msg);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("%0t mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
		if (got !== want)
			flag_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	task automatic predict_deque(cmd_t op, logic [DATA_W-1:0] v);
		deque_view_t view;
		slot_t       tail;
		slot_t       pos;
		view.status = ST_OK;
		tail = (fill == 0) ? head : slot_t'(head + slot_t'(fill - 1'b1));
		case (op)
			CMD_PUSH_FRONT: begin
				if (fill == CNT_W'(DEPTH)) begin
					view.status = ST_FULL;
				end else begin
					head = head - 1'b1;
					ring[head] = v;
					fill = fill + 1'b1;
				end
			end
			CMD_PUSH_BACK: begin
				if (fill == CNT_W'(DEPTH)) begin
					view.status = ST_FULL;
				end else begin
					ring[slot_t'(head + slot_t'(fill))] = v;
					fill = fill + 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (fill == 0) begin
					view.status = ST_EMPTY;
				end else begin
					if (cur_on && cur == head)
						cur_on = 1'b0;
					head = head + 1'b1;
					fill = fill - 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (fill == 0) begin
					view.status = ST_EMPTY;
				end else begin
					if (cur_on && cur == tail)
						cur_on = 1'b0;
					fill = fill - 1'b1;
				end
			end
			CMD_CLEAR: begin
				fill = '0;
				head = '0;
				cur_on = 1'b0;
			end
			CMD_CURSOR_FIRST: begin
				cur_on = (fill != 0);
				if (cur_on)
					cur = head;
			end
			CMD_CURSOR_LAST: begin
				cur_on = (fill != 0);
				if (cur_on)
					cur = tail;
			end
			CMD_CURSOR_NEXT: begin
				if (!cur_on)
					view.status = ST_NULL;
				else if (cur == tail)
					cur_on = 1'b0;
				else
					cur = cur + 1'b1;
			end
			CMD_CURSOR_PREV: begin
				if (!cur_on)
					view.status = ST_NULL;
				else if (cur == head)
					cur_on = 1'b0;
				else
					cur = cur - 1'b1;
			end
			default: begin
			end
		endcase
		pos = cur - head;
		view.count        = fill;
		view.is_empty     = (fill == 0);
		view.cursor_valid = cur_on;
		view.cursor_data  = cur_on ? ring[cur] : '0;
		view.has_next     = cur_on && (CNT_W'(pos) + 1'b1 != fill);
		view.has_prev     = cur_on && (pos != 0);
		expected_views.push_back(view);
	endtask

	// command driver
	always @(negedge clk) begin : cmd_driver
		deque_cmd_t beat;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else if (!cmd_ch.valid || cmd_beat) begin
			if (cmd_gap != 0) begin
				cmd_ch.valid <= 1'b0;
				cmd_gap <= cmd_gap - 1;
			end else if (pending_cmds.size() != 0) begin
				beat = pending_cmds.pop_front();
				cmd_ch.valid <= 1'b1;
				cmd_ch.command <= beat.op;
				cmd_ch.value <= beat.value;
				cmd_gap <= pick_gap();
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver, with one long hold-off to back up the command side
	always @(negedge clk) begin : res_receiver
		int g;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			res_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && cmds_taken >= HOLD_AT) begin
			res_ch.ready <= 1'b0;
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end else if (res_gap != 0) begin
			res_ch.ready <= 1'b0;
			res_gap <= res_gap - 1;
		end else if (res_beat) begin
			g = pick_gap();
			res_ch.ready <= (g == 0);
			res_gap <= (g == 0) ? 0 : g - 1;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// monitor: check result beats first, then predict from the command beat
	always @(posedge clk or negedge arst_n) begin : monitor
		deque_view_t want;
		if (!arst_n) begin
			cmd_beat <= 1'b0;
			res_beat <= 1'b0;
		end else begin
			cmd_beat <= cmd_ch.valid && cmd_ch.ready;
			res_beat <= res_ch.valid && res_ch.ready;
			if (res_ch.valid && res_ch.ready) begin
				if (expected_views.size() == 0) begin
					flag_error("result beat with nothing expected");
				end else begin
					want = expected_views.pop_front();
					check_field("status", res_ch.status, want.status);
					check_field("count", res_ch.count, want.count);
					check_field("is_empty", res_ch.is_empty, want.is_empty);
					check_field("cursor_valid", res_ch.cursor_valid, want.cursor_valid);
					check_field("cursor_data", res_ch.cursor_data, want.cursor_data);
					check_field("has_next", res_ch.has_next, want.has_next);
					check_field("has_prev", res_ch.has_prev, want.has_prev);
				end
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				predict_deque(cmd_ch.command, cmd_ch.value);
				cmds_taken++;
			end
		end
	end

	// watchdog; also switches calm stretches with no idling on and off
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_no++;
			if (cycle_no % 256 == 0)
				calm <= ($urandom_range(0, 3) == 0);
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("bounded_deque_with_cursor_tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		int n;
		int i;
		bit fwd;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_QUERY;
		cmd_ch.value = '0;
		res_ch.ready = 1'b0;
		head = '0;
		fill = '0;
		cur = '0;
		cur_on = 1'b0;
		foreach (ring[k])
			ring[k] = '0;

		// directed: empty-queue errors, sole element, steps off both ends, spare codes
		add_rand(CMD_QUERY);
		add_rand(CMD_POP_FRONT);
		add_rand(CMD_POP_BACK);
		add_rand(CMD_CURSOR_NEXT);
		add_rand(CMD_CURSOR_PREV);
		add_rand(CMD_CURSOR_FIRST);
		add_rand(CMD_CURSOR_LAST);
		add_cmd(CMD_PUSH_FRONT, '1);
		add_rand(CMD_CURSOR_FIRST);
		add_rand(CMD_POP_BACK);
		add_cmd(CMD_PUSH_BACK, '0);
		add_cmd(CMD_PUSH_FRONT, 32'hA5A5_5A5A);
		add_cmd(CMD_PUSH_BACK, 32'h8000_0001);
		add_rand(CMD_CURSOR_LAST);
		add_rand(CMD_CURSOR_PREV);
		add_rand(CMD_CURSOR_PREV);
		add_rand(CMD_CURSOR_PREV);
		add_rand(CMD_CURSOR_FIRST);
		add_rand(CMD_POP_FRONT);
		add_rand(CMD_CURSOR_LAST);
		add_rand(CMD_CURSOR_NEXT);
		add_rand(cmd_t'(CMD_QUERY + 4'd1));
		add_rand(cmd_t'(CMD_CODE_LAST));
		add_rand(CMD_CLEAR);
		add_rand(CMD_QUERY);

		n = pending_cmds.size() + RANDOM_CMDS;
		while (pending_cmds.size() < n) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					repeat ($urandom_range(8, 20))
						add_rand($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT);
				end
				2: begin
					repeat ($urandom_range(4, 18))
						add_rand($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT);
				end
				3, 4, 5: begin
					fwd = $urandom_range(0, 1);
					add_rand(fwd ? CMD_CURSOR_FIRST : CMD_CURSOR_LAST);
					repeat ($urandom_range(3, 20)) begin
						i = $urandom_range(0, 9);
						if (i < 6)
							add_rand(fwd ? CMD_CURSOR_NEXT : CMD_CURSOR_PREV);
						else if (i == 6)
							add_rand(fwd ? CMD_CURSOR_PREV : CMD_CURSOR_NEXT);
						else if (i == 7)
							add_rand($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT);
						else if (i == 8)
							add_rand($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT);
						else
							add_rand(CMD_QUERY);
					end
				end
				6: add_rand($urandom_range(0, 1) ? CMD_CLEAR : CMD_QUERY);
				default: begin
					repeat ($urandom_range(1, 10))
						add_rand(cmd_t'($urandom_range(0, CMD_CODE_LAST)));
				end
			endcase
		end

		repeat (6) @(posedge clk);
		#1 arst_n = 1'b1;

		while (pending_cmds.size() != 0 || cmd_ch.valid)
			@(posedge clk);
		while (expected_views.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("bounded_deque_with_cursor_tb: PASS");
		else
			$display("bounded_deque_with_cursor_tb: FAIL");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/bdq_pkg.sv
hdl/bdq_if.sv
hdl/bdq_ram.sv
hdl/bounded_deque_with_cursor.sv
hdl/bdq_checker.sv
dv/bounded_deque_with_cursor_tb.sv
